[src/nise_pkg.sv]
package nise_pkg;

    localparam int NEIGHBOR_SLOTS = 8;
    localparam int SET_SLOTS      = 16;
    localparam int MIN_DEGREE     = 3;
    localparam int NB_W           = $clog2(NEIGHBOR_SLOTS);
    localparam int CNT_W          = $clog2(NEIGHBOR_SLOTS + 1);
    localparam int SET_AW         = $clog2(SET_SLOTS);
    localparam int SET_CW         = $clog2(SET_SLOTS + 1);
    localparam int WT_W           = 32;
    localparam int SUM_W          = 35;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] ST_SET      = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;
    localparam logic [1:0] ST_DEGREE   = 2'd3;

    localparam logic CFG_MAX_DEGREE = 1'b0;
    localparam logic CFG_MAX_SETS   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic srch_start;
        logic srch_step;
        logic emit_load;
        logic emit_next;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic leaf_done;
        logic abort;
        logic emit_last;
        logic sets_zero;
    } t_sts;

endpackage

[src/nise_if.sv]
interface nise_in_if;
    logic                        valid;
    logic                        ready;
    logic [nise_pkg::WT_W-1:0]   neighbor_weight;
    logic [7:0]                  adjacency_row;
    logic [nise_pkg::WT_W-1:0]   center_weight;
    logic                        last;
    modport source (output valid, neighbor_weight, adjacency_row, center_weight, last,
                    input ready);
    modport sink (input valid, neighbor_weight, adjacency_row, center_weight, last,
                  output ready);
endinterface

interface nise_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [7:0]                   set_mask;
    logic [nise_pkg::SUM_W-1:0]   set_weight;
    logic [4:0]                   set_count;
    logic                         end_of_run;
    modport source (output valid, status, set_mask, set_weight, set_count, end_of_run,
                    input ready);
    modport sink (input valid, status, set_mask, set_weight, set_count, end_of_run,
                  output ready);
endinterface

interface nise_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [4:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/nise_ram.sv]
module nise_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[src/nise_datapath.sv]
// depth-first search as an explicit stack of per-level branch marks;
// one tree node per cycle, leaf weight accumulated along the path
module nise_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nise_pkg::t_cmd                i_cmd,
    input  logic [nise_pkg::WT_W-1:0]     i_weight,
    input  logic [7:0]                    i_adj,
    input  logic [nise_pkg::WT_W-1:0]     i_center,
    input  logic [nise_pkg::SET_CW-1:0]   i_limit,
    output nise_pkg::t_sts                o_sts,
    output logic [nise_pkg::CNT_W-1:0]    o_degree,
    output logic                          o_overflow,
    output logic [7:0]                    o_mask,
    output logic [nise_pkg::SUM_W-1:0]    o_weight,
    output logic [4:0]                    o_count
);
    localparam int N = nise_pkg::NEIGHBOR_SLOTS;

    logic [nise_pkg::WT_W-1:0]  r_wt [N];
    logic [N-1:0]               r_adj [N];
    logic [nise_pkg::CNT_W-1:0] r_cnt;
    logic                       r_ovf;
    logic [nise_pkg::WT_W-1:0]  r_center;

    // per level: chosen set, blocked set, cost on entry, and branch mark
    logic [N-1:0]               r_ch  [N+1];
    logic [N-1:0]               r_bl  [N+1];
    logic [nise_pkg::SUM_W-1:0] r_cs  [N+1];
    logic [N-1:0]               r_mark;
    logic [nise_pkg::CNT_W-1:0] r_pos;
    logic                       r_leaf_done;
    logic                       r_abort;
    logic [nise_pkg::SET_CW-1:0] r_found;
    logic [nise_pkg::SET_CW-1:0] r_rd;

    logic [nise_pkg::NB_W-1:0]  pos_i;
    logic [N-1:0]               adj_m;
    logic [nise_pkg::SUM_W:0]   sum_w;
    logic [nise_pkg::SUM_W-1:0] inc_cs;
    logic [N-1:0]               leaf_ch;
    logic [nise_pkg::SUM_W-1:0] leaf_cs;
    logic                       at_leaf;
    logic                       qual;
    logic                       bt_found;
    logic [nise_pkg::CNT_W-1:0] bt_lvl;
    logic                       we;
    logic [nise_pkg::SET_AW-1:0] rd_a;

    assign pos_i   = r_pos[nise_pkg::NB_W-1:0];
    assign at_leaf = (r_pos == r_cnt);
    assign leaf_ch = r_ch[r_pos];
    assign leaf_cs = r_cs[r_pos];
    assign qual    = at_leaf && (leaf_cs > {3'b0, r_center});
    assign sum_w   = {1'b0, r_cs[r_pos]} + {4'b0, r_wt[pos_i]};
    assign inc_cs  = sum_w[nise_pkg::SUM_W] ? nise_pkg::SUM_MAX
                                            : sum_w[nise_pkg::SUM_W-1:0];
    assign we      = i_cmd.srch_step && qual && (r_found < i_limit);

    // deepest level whose include branch is open: go take its exclude branch
    always_comb begin
        bt_found = 1'b0;
        bt_lvl   = '0;
        for (int k = 0; k < N; k++) begin
            if (k < r_cnt && r_mark[k]) begin
                bt_found = 1'b1;
                bt_lvl   = nise_pkg::CNT_W'(k);
            end
        end
    end

    always_comb begin
        adj_m = '0;
        for (int k = 0; k < N; k++) adj_m[k] = (k < r_cnt) && r_adj[pos_i][k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < nise_pkg::CNT_W'(N)) begin
            r_wt[r_cnt[nise_pkg::NB_W-1:0]]  <= i_weight;
            r_adj[r_cnt[nise_pkg::NB_W-1:0]] <= i_adj[N-1:0];
        end
        if (i_cmd.load) r_center <= i_center;
        if (i_cmd.srch_start) begin
            r_ch[0] <= '0;
            r_bl[0] <= '0;
            r_cs[0] <= '0;
        end else if (i_cmd.srch_step && !at_leaf) begin
            if (r_bl[r_pos][pos_i]) begin
                r_ch[r_pos+1'b1] <= r_ch[r_pos];
                r_bl[r_pos+1'b1] <= r_bl[r_pos];
                r_cs[r_pos+1'b1] <= r_cs[r_pos];
            end else begin
                r_ch[r_pos+1'b1] <= r_ch[r_pos] | (N'(1) << pos_i);
                r_bl[r_pos+1'b1] <= r_bl[r_pos] | adj_m;
                r_cs[r_pos+1'b1] <= inc_cs;
            end
        end else if (i_cmd.srch_step && at_leaf && bt_found) begin
            r_ch[bt_lvl+1'b1] <= r_ch[bt_lvl];
            r_bl[bt_lvl+1'b1] <= r_bl[bt_lvl];
            r_cs[bt_lvl+1'b1] <= r_cs[bt_lvl];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_mark <= '0;
            r_pos <= '0;
            r_leaf_done <= 1'b0;
            r_abort <= 1'b0;
            r_found <= '0;
            r_rd <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_cnt < nise_pkg::CNT_W'(N)) r_cnt <= r_cnt + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (i_cmd.srch_start) begin
                r_pos <= '0;
                r_mark <= '0;
            end else if (i_cmd.srch_step) begin
                if (!at_leaf) begin
                    if (!r_bl[r_pos][pos_i]) r_mark[pos_i] <= 1'b1;
                    r_pos <= r_pos + 1'b1;
                end else begin
                    if (qual) begin
                        if (r_found < i_limit) r_found <= r_found + 1'b1;
                        else r_abort <= 1'b1;
                    end
                    if (!bt_found || (qual && r_found >= i_limit)) begin
                        r_leaf_done <= 1'b1;
                    end else begin
                        r_mark[bt_lvl[nise_pkg::NB_W-1:0]] <= 1'b0;
                        r_pos <= bt_lvl + 1'b1;
                    end
                end
            end
            if (i_cmd.emit_load) r_rd <= nise_pkg::SET_CW'(1);
            else if (i_cmd.emit_next) r_rd <= r_rd + 1'b1;
        end
    end

    // r_rd points one past the set on show: step ahead only when the request
    // is taken, otherwise keep re-reading the set on show
    assign rd_a = i_cmd.emit_load ? '0
                : i_cmd.emit_next ? r_rd[nise_pkg::SET_AW-1:0]
                : r_rd[nise_pkg::SET_AW-1:0] - 1'b1;

    nise_ram #(.WIDTH(N), .DEPTH(nise_pkg::SET_SLOTS)) u_mask_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_found[nise_pkg::SET_AW-1:0]),
        .i_wdata(leaf_ch), .i_raddr(rd_a), .o_rdata(o_mask)
    );
    nise_ram #(.WIDTH(nise_pkg::SUM_W), .DEPTH(nise_pkg::SET_SLOTS)) u_wt_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_found[nise_pkg::SET_AW-1:0]),
        .i_wdata(leaf_cs), .i_raddr(rd_a), .o_rdata(o_weight)
    );

    assign o_sts.leaf_done = r_leaf_done;
    assign o_sts.abort     = r_abort;
    assign o_sts.emit_last = (r_rd >= r_found);
    assign o_sts.sets_zero = (r_found == '0);
    assign o_degree   = r_cnt;
    assign o_overflow = r_ovf;
    assign o_count    = 5'(r_found);
endmodule

[src/nise_ctrl.sv]
module nise_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_last,
    output logic                          o_in_ready,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_out_final,
    output logic [1:0]                    o_out_status,
    input  logic [3:0]                    i_max_degree,
    input  nise_pkg::t_sts                i_sts,
    input  logic [nise_pkg::CNT_W-1:0]    i_degree,
    input  logic                          i_overflow,
    output nise_pkg::t_cmd                o_cmd
);
    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SEARCH = 6'b000100,
        S_PRIME  = 6'b001000,
        S_EMIT   = 6'b010000,
        S_STATUS = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       acc, take, bad;

    assign acc  = i_in_valid && o_in_ready;
    assign take = o_out_valid && i_out_ready;
    assign bad  = i_overflow || i_degree < nise_pkg::CNT_W'(nise_pkg::MIN_DEGREE)
                  || 5'(i_degree) > {1'b0, i_max_degree};

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_out_final  = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = acc;
                if (acc && i_in_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (bad) begin
                    n_status = nise_pkg::ST_DEGREE;
                    n_state  = S_STATUS;
                end else begin
                    o_cmd.srch_start = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.srch_step = !i_sts.leaf_done;
                if (i_sts.leaf_done) n_state = S_PRIME;
            end
            S_PRIME: begin
                if (i_sts.abort) begin
                    n_status = nise_pkg::ST_TOO_MANY;
                    n_state  = S_STATUS;
                end else if (i_sts.sets_zero) begin
                    n_status = nise_pkg::ST_DONE;
                    n_state  = S_STATUS;
                end else begin
                    o_cmd.emit_load = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (take) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_sts.emit_last) begin
                        n_status = nise_pkg::ST_DONE;
                        n_state  = S_STATUS;
                    end
                end
            end
            S_STATUS: begin
                o_out_valid = 1'b1;
                o_out_final = 1'b1;
                if (take) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_out_status = o_out_final ? r_status : nise_pkg::ST_SET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_status <= nise_pkg::ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end
endmodule

[src/neighborhood_independent_set_enum.sv]
// Loads one neighbour per request; the request with last set also brings the
// centre weight and, if the degree check passes, starts a depth-first search
// that visits one tree node per cycle. Unless the set limit is hit, stored sets
// are then sent one per cycle while the sink is ready, from a registered set
// memory, followed by the status request; a new neighbourhood is accepted once
// the status has been taken.
module neighborhood_independent_set_enum (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nise_in_if.sink    in_ch,
    nise_out_if.source out_ch,
    nise_cfg_if.sink   cfg_ch
);
    logic [3:0]                 r_max_degree;
    logic [4:0]                 r_max_sets;
    logic [nise_pkg::SET_CW-1:0] limit;
    nise_pkg::t_cmd             cmd;
    nise_pkg::t_sts             sts;
    logic [nise_pkg::CNT_W-1:0] degree;
    logic                       ovf;
    logic                       out_final;
    logic [7:0]                 d_mask;
    logic [nise_pkg::SUM_W-1:0] d_weight;
    logic [4:0]                 d_count;
    logic [7:0]                 adj_in;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_degree <= 4'd8;
            r_max_sets   <= 5'd16;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                nise_pkg::CFG_MAX_DEGREE: r_max_degree <= cfg_ch.data[3:0];
                default:                  r_max_sets   <= cfg_ch.data;
            endcase
        end
    end

    assign limit = (6'(r_max_sets) < 6'(nise_pkg::SET_SLOTS))
                   ? nise_pkg::SET_CW'(r_max_sets) : nise_pkg::SET_CW'(nise_pkg::SET_SLOTS);
    assign adj_in = in_ch.adjacency_row;

    nise_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_last(in_ch.last), .o_in_ready(in_ch.ready),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid), .o_out_final(out_final),
        .o_out_status(out_ch.status), .i_max_degree(r_max_degree),
        .i_sts(sts), .i_degree(degree), .i_overflow(ovf), .o_cmd(cmd)
    );

    nise_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_weight(in_ch.neighbor_weight), .i_adj(adj_in), .i_center(in_ch.center_weight),
        .i_limit(limit), .o_sts(sts), .o_degree(degree), .o_overflow(ovf),
        .o_mask(d_mask), .o_weight(d_weight), .o_count(d_count)
    );

    assign out_ch.set_mask   = out_final ? 8'd0 : d_mask;
    assign out_ch.set_weight = out_final ? '0 : d_weight;
    assign out_ch.set_count  = (out_final && out_ch.status != nise_pkg::ST_DEGREE)
                               ? d_count : 5'd0;
    assign out_ch.end_of_run = out_final;
endmodule

[src/nise_checker.sv]
module nise_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [7:0] set_mask,
    input logic [4:0] set_count,
    input logic       end_of_run
);
    a_no_input_while_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    a_eor_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && end_of_run |-> status != 2'd0 && set_mask == 8'd0)
        else $error("bad final status");
    a_set_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !end_of_run |-> status == 2'd0 && set_count == 5'd0)
        else $error("bad set request");
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output dropped");
endmodule

bind neighborhood_independent_set_enum nise_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .set_mask(out_ch.set_mask),
    .set_count(out_ch.set_count), .end_of_run(out_ch.end_of_run)
);

[sim/tb_neighborhood_independent_set_enum.sv]
class set_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  set_mask;
        logic [34:0] set_weight;
        logic [4:0]  set_count;
        logic        end_of_run;
    } t_result;

    logic [31:0] nb_weight [8];
    logic [7:0]  nb_adj [8];
    int unsigned n_loaded;
    bit          overflow;
    int unsigned max_degree;
    int unsigned max_sets;
    t_result     pending[$];
    int unsigned n_found;
    bit          aborted;
    logic [7:0]  found_mask [16];
    logic [34:0] found_weight [16];
    int unsigned limit;
    int unsigned degree;
    logic [31:0] centre;
    int          errors;
    int unsigned sets_seen;
    int unsigned status_seen [4];

    function new();
        n_loaded   = 0;
        overflow   = 0;
        max_degree = 8;
        max_sets   = 16;
        errors     = 0;
        sets_seen  = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(bit idx, logic [4:0] val);
        if (idx == nise_pkg::CFG_MAX_DEGREE) max_degree = val[3:0];
        else max_sets = val;
    endfunction

    function logic [34:0] weigh(logic [7:0] m);
        logic [35:0] s;
        s = 0;
        for (int i = 0; i < degree; i++)
            if (m[i]) begin
                s = s + nb_weight[i];
                if (s > {1'b0, nise_pkg::SUM_MAX}) s = {1'b0, nise_pkg::SUM_MAX};
            end
        return s[34:0];
    endfunction

    function void search(int unsigned pos, logic [7:0] chosen, logic [7:0] blocked);
        logic [34:0] w;
        if (aborted) return;
        if (pos >= degree) begin
            w = weigh(chosen);
            if (w > {3'b0, centre}) begin
                if (n_found >= limit) begin
                    aborted = 1;
                    return;
                end
                found_mask[n_found]   = chosen;
                found_weight[n_found] = w;
                n_found++;
            end
            return;
        end
        if (blocked[pos]) begin
            search(pos + 1, chosen, blocked);
            return;
        end
        search(pos + 1, chosen | (8'd1 << pos), blocked | nb_adj[pos]);
        search(pos + 1, chosen, blocked);
    endfunction

    function void push(logic [1:0] st, logic [7:0] m, logic [34:0] w, int unsigned c,
                       bit e);
        t_result r;
        r.status = st; r.set_mask = m; r.set_weight = w;
        r.set_count = c[4:0]; r.end_of_run = e;
        pending.push_back(r);
    endfunction

    function void note_request(logic [31:0] nw, logic [7:0] adj, logic [31:0] cw, bit lst);
        if (n_loaded < 8) begin
            nb_weight[n_loaded] = nw;
            nb_adj[n_loaded]    = adj;
            n_loaded++;
        end else begin
            overflow = 1;
        end
        if (!lst) return;
        degree  = n_loaded;
        centre  = cw;
        limit   = (max_sets < 16) ? max_sets : 16;
        aborted = 0;
        n_found = 0;
        if (overflow || degree < nise_pkg::MIN_DEGREE || degree > max_degree) begin
            push(nise_pkg::ST_DEGREE, 0, 0, 0, 1);
        end else begin
            search(0, 0, 0);
            if (aborted) begin
                push(nise_pkg::ST_TOO_MANY, 0, 0, n_found, 1);
            end else begin
                for (int i = 0; i < n_found; i++)
                    push(nise_pkg::ST_SET, found_mask[i], found_weight[i], 0, 0);
                push(nise_pkg::ST_DONE, 0, 0, n_found, 1);
            end
        end
        n_loaded = 0;
        overflow = 0;
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        errors++;
    endfunction

    function void check_result(t_result got);
        t_result exp_r;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result status %0d", got.status));
            return;
        end
        exp_r = pending.pop_front();
        status_seen[got.status]++;
        if (got.status == nise_pkg::ST_SET) sets_seen++;
        if (got.status !== exp_r.status)
            report($sformatf("status %0d, wanted %0d", got.status, exp_r.status));
        if (got.set_mask !== exp_r.set_mask)
            report($sformatf("set_mask %h, wanted %h", got.set_mask, exp_r.set_mask));
        if (got.set_weight !== exp_r.set_weight)
            report($sformatf("set_weight %h, wanted %h", got.set_weight, exp_r.set_weight));
        if (got.set_count !== exp_r.set_count)
            report($sformatf("set_count %0d, wanted %0d", got.set_count, exp_r.set_count));
        if (got.end_of_run !== exp_r.end_of_run)
            report($sformatf("end_of_run %b, wanted %b", got.end_of_run, exp_r.end_of_run));
    endfunction
endclass

module tb_neighborhood_independent_set_enum;

    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    nise_in_if  in_ch();
    nise_out_if out_ch();
    nise_cfg_if cfg_ch();

    neighborhood_independent_set_enum u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    set_scoreboard sb;
    bit calm;
    bit long_hold;
    int unsigned idle_cycles;
    int unsigned hoods;

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.neighbor_weight = '0;
        in_ch.adjacency_row = '0;
        in_ch.center_weight = '0;
        in_ch.last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        calm = 0;
        long_hold = 0;
    end

    // result sink with random back-pressure
    initial begin
        int unsigned n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                long_hold = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.status, out_ch.set_mask, out_ch.set_weight,
                             out_ch.set_count, out_ch.end_of_run});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid stays up after an accepted request until a gap, a drain or the end
    task automatic send_neighbour(logic [31:0] nw, logic [7:0] adj, logic [31:0] cw, bit lst);
        int unsigned g;
        if (!calm && $urandom_range(0, 4) == 0) begin
            g = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.neighbor_weight <= nw;
        in_ch.adjacency_row <= adj;
        in_ch.center_weight <= cw;
        in_ch.last <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_request(nw, adj, cw, lst);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_register(bit idx, logic [4:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_register(idx, val);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 4))
            0: return '1;
            1: return 32'd0;
            2: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_hood(int unsigned deg, int unsigned density, logic [31:0] cw);
        logic [7:0] adj;
        for (int i = 0; i < deg; i++) begin
            adj = 0;
            for (int j = 0; j < 8; j++)
                if ($urandom_range(0, 99) < density) adj[j] = 1'b1;
            send_neighbour(pick_weight(), adj, cw, i == deg - 1);
        end
        hoods++;
    endtask

    initial begin
        int unsigned deg;
        logic [31:0] cw;
        hoods = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of degree, weights and centre
        send_neighbour('1, 8'hff, 32'd0, 0);
        send_neighbour('1, 8'h00, 32'd0, 0);
        send_neighbour('1, 8'h00, 32'd0, 1);
        send_neighbour(32'd5, 8'h00, 32'd0, 0);
        send_neighbour(32'd5, 8'h00, 32'd0, 1);                  // too few neighbours
        send_neighbour(32'd1, 8'h00, '1, 0);
        send_neighbour(32'd1, 8'h00, '1, 0);
        send_neighbour(32'd1, 8'h00, '1, 1);                     // nothing beats centre
        for (int i = 0; i < 9; i++)
            send_neighbour('1, 8'h00, 32'd3, i == 8);           // overflow past slots
        send_neighbour(32'd2, 8'h06, 32'd1, 0);
        send_neighbour(32'd2, 8'h01, 32'd1, 0);
        send_neighbour(32'd2, 8'h01, 32'd1, 1);                  // adjacency blocking

        write_register(nise_pkg::CFG_MAX_SETS, 5'd1);
        send_hood(4, 0, 32'd0);                                  // set limit abort
        write_register(nise_pkg::CFG_MAX_SETS, 5'd0);
        send_hood(3, 20, 32'd0);
        write_register(nise_pkg::CFG_MAX_SETS, 5'd31);
        write_register(nise_pkg::CFG_MAX_DEGREE, 5'd3);
        send_hood(4, 30, 32'd10);
        send_hood(3, 30, 32'd10);
        write_register(nise_pkg::CFG_MAX_DEGREE, 5'd15);

        // random neighbourhoods over several settings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_register(nise_pkg::CFG_MAX_DEGREE, 5'd8);
                    write_register(nise_pkg::CFG_MAX_SETS, 5'd16);
                end
                2: begin
                    write_register(nise_pkg::CFG_MAX_DEGREE, 5'($urandom_range(3, 7)));
                    write_register(nise_pkg::CFG_MAX_SETS, 5'($urandom_range(1, 15)));
                end
                3: write_register(nise_pkg::CFG_MAX_DEGREE, 5'd0);
                4: begin
                    write_register(nise_pkg::CFG_MAX_DEGREE, 5'd8);
                    write_register(nise_pkg::CFG_MAX_SETS, 5'd20);
                end
                5: calm = 1;
                default: ;
            endcase
            for (int h = 0; h < 8; h++) begin
                if (phase == 1 && h == 2) long_hold = 1;
                if (phase == 2 && h == 4) drain();
                deg = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10)
                                                  : $urandom_range(3, 6);
                cw = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 60);
                send_hood(deg, $urandom_range(10, 90), cw);
            end
        end

        drain();
        $display("covered %0d neighbourhoods, %0d sets, %0d done, %0d too many, %0d degree",
                 hoods, sb.sets_seen, sb.status_seen[nise_pkg::ST_DONE],
                 sb.status_seen[nise_pkg::ST_TOO_MANY], sb.status_seen[nise_pkg::ST_DEGREE]);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
